// File: design/lcs_length_engine_assert.svh
// Assertion macros shared by the LCS length engine RTL.
`ifndef LCS_LENGTH_ENGINE_ASSERT_SVH
`define LCS_LENGTH_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LCS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lcs_pkg.sv
// Package: constants, command codes and cell control type of the LCS length engine.
`default_nettype none

package lcs_pkg;

    // Field widths of the stream ports
    localparam int CMD_W       = 2;
    localparam int SYM_FIELD_W = 8;
    localparam int LEN_FIELD_W = 7;

    // Parameter defaults
    localparam int DEFAULT_MAX_LEN     = 64;
    localparam int DEFAULT_SYMBOL_BITS = 8;

    // Commands carried on s_tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND_FIRST  = 2'd0,
        CMD_APPEND_SECOND = 2'd1,
        CMD_FINISH        = 2'd2
    } cmd_t;

    // Control from the top level to one cell
    typedef struct packed {
        logic clear;  // drop stored symbol and score
        logic load;   // store a first-string symbol
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/lcs_cell.sv
// One cell of the LCS chain: a first-string symbol, its score, and a wave stage.
`default_nettype none

module lcs_cell
    import lcs_pkg::*;
#(
    parameter int SYMBOL_BITS = DEFAULT_SYMBOL_BITS,
    parameter int SCORE_W     = 7
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cell_ctl_t              ctl,
    input  wire logic [SYMBOL_BITS-1:0] wr_sym,
    input  wire logic                   in_vld,
    input  wire logic [SYMBOL_BITS-1:0] in_sym,
    input  wire logic [SCORE_W-1:0]     in_diag,
    input  wire logic [SCORE_W-1:0]     in_left,
    output logic                        out_vld,
    output logic [SYMBOL_BITS-1:0]      out_sym,
    output logic [SCORE_W-1:0]          out_diag,
    output logic [SCORE_W-1:0]          out_left
);

    logic                   used_reg;
    logic [SYMBOL_BITS-1:0] sym_reg;
    logic [SCORE_W-1:0]     score_reg;
    logic                   out_vld_reg;
    logic [SYMBOL_BITS-1:0] out_sym_reg;
    logic [SCORE_W-1:0]     out_diag_reg;
    logic [SCORE_W-1:0]     out_left_reg;
    logic                   match;
    logic [SCORE_W-1:0]     score_next;

    // Recurrence: diagonal plus one on a match, else the larger neighbour
    assign match      = used_reg && (in_sym != '0) && (sym_reg == in_sym);
    assign score_next = match ? SCORE_W'(in_diag + 1'b1)
                              : ((in_left > score_reg) ? in_left : score_reg);

    // Cell state and the stage handed to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= 1'b0;
            score_reg    <= '0;
            out_vld_reg  <= 1'b0;
            out_left_reg <= '0;
        end else begin
            out_vld_reg <= in_vld;
            if (ctl.clear) begin
                used_reg     <= 1'b0;
                score_reg    <= '0;
                out_left_reg <= '0;
            end else begin
                if (ctl.load) begin
                    used_reg <= 1'b1;
                    sym_reg  <= wr_sym;
                end
                if (in_vld) begin
                    out_sym_reg  <= in_sym;
                    out_diag_reg <= score_reg;
                    if (used_reg) begin
                        score_reg    <= score_next;
                        out_left_reg <= score_next;
                    end else begin
                        // unused cells pass the last score through
                        out_left_reg <= in_left;
                    end
                end
            end
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_sym  = out_sym_reg;
    assign out_diag = out_diag_reg;
    assign out_left = out_left_reg;

endmodule

`default_nettype wire

// File: design/lcs_length_engine.sv
// Top level: LCS length engine built as a systolic chain of cells.
//
// Usage:
// - Input stream s_*: s_tuser carries the command (append to first string,
//   append to second string, finish), s_tdata the symbol.
// - Result stream m_*: one transaction per finish; m_tdata holds the LCS
//   length, m_tuser the flag for appends dropped since the last finish.
// - First-string symbols are written straight into cell N. Each second-string
//   symbol starts a wave that moves one cell per cycle down the MAX_LEN cells.
// - Appends are taken every cycle, so waves follow one another back to back.
// - A finish is held off until the last wave has left the chain, so the wait
//   after the last second-string symbol is set by the length of the chain.
//   The result is shown in the cycle after the finish.
// - The result sits in an output register; while it waits on m_tready,
//   appends still flow, and only a further finish stalls.
// - Reset (aresetn low, synchronous) empties both strings, zeroes the scores
//   and the drop flag, and drops any result not yet taken. A finish does the
//   same clearing after it captures the result.
`default_nettype none

module lcs_length_engine
    import lcs_pkg::*;
#(
    parameter int MAX_LEN     = DEFAULT_MAX_LEN,
    parameter int SYMBOL_BITS = DEFAULT_SYMBOL_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] lcs_length, [7] zero
    output logic [0:0]       m_tuser    // [0] dropped
);

    `include "lcs_length_engine_assert.svh"

    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int DRAIN_W = $clog2(MAX_LEN + 2);

    cmd_t                   cmd;
    logic [SYMBOL_BITS-1:0] sym_in;
    logic                   accept;
    logic                   fin_ok;
    logic                   drain_zero;
    logic                   first_full;
    logic                   second_full;
    logic                   first_wr;

    logic [CNT_W-1:0]       first_len_reg;
    logic [CNT_W-1:0]       second_len_reg;
    logic [DRAIN_W-1:0]     drain_reg;
    logic                   drop_reg;
    logic                   wave_vld_reg;
    logic [SYMBOL_BITS-1:0] wave_sym_reg;
    logic                   m_valid_reg;
    logic [LEN_FIELD_W-1:0] m_len_reg;
    logic                   m_drop_reg;

    // Wave chain: stage 0 is driven here, stage MAX_LEN leaves the last cell
    logic [MAX_LEN:0]                  chain_vld;
    logic [MAX_LEN:0][SYMBOL_BITS-1:0] chain_sym;
    logic [MAX_LEN:0][CNT_W-1:0]       chain_diag;
    logic [MAX_LEN:0][CNT_W-1:0]       chain_left;

    // Input decode and handshake
    assign cmd         = cmd_t'(s_tuser);
    assign sym_in      = SYMBOL_BITS'(s_tdata);
    assign drain_zero  = (drain_reg == '0);
    assign fin_ok      = drain_zero && (!m_valid_reg || m_tready);
    assign s_tready    = (cmd != CMD_FINISH) || fin_ok;
    assign accept      = s_tvalid && s_tready;
    assign first_full  = (first_len_reg == CNT_W'(MAX_LEN));
    assign second_full = (second_len_reg == CNT_W'(MAX_LEN));
    assign first_wr    = accept && (cmd == CMD_APPEND_FIRST)
                         && (second_len_reg == '0) && !first_full;

    // Control, wave injection and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            drain_reg      <= '0;
            drop_reg       <= 1'b0;
            wave_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            wave_vld_reg <= 1'b0;
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (!drain_zero) begin
                drain_reg <= drain_reg - 1'b1;
            end
            if (accept) begin
                case (cmd)
                    CMD_APPEND_FIRST: begin
                        if (first_wr) begin
                            first_len_reg <= first_len_reg + 1'b1;
                        end else begin
                            drop_reg <= 1'b1;
                        end
                    end
                    CMD_APPEND_SECOND: begin
                        if (second_full) begin
                            drop_reg <= 1'b1;
                        end else begin
                            second_len_reg <= second_len_reg + 1'b1;
                            wave_vld_reg   <= 1'b1;
                            wave_sym_reg   <= sym_in;
                            // injection stage plus one stage per cell
                            drain_reg      <= DRAIN_W'(MAX_LEN + 1);
                        end
                    end
                    CMD_FINISH: begin
                        m_valid_reg    <= 1'b1;
                        m_len_reg      <= LEN_FIELD_W'(chain_left[MAX_LEN]);
                        m_drop_reg     <= drop_reg;
                        first_len_reg  <= '0;
                        second_len_reg <= '0;
                        drop_reg       <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign chain_vld[0]  = wave_vld_reg;
    assign chain_sym[0]  = wave_sym_reg;
    assign chain_diag[0] = '0;
    assign chain_left[0] = '0;

    // Row of cells, one per first-string position
    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        cell_ctl_t ctl;

        assign ctl.clear = accept && (cmd == CMD_FINISH);
        assign ctl.load  = first_wr && (first_len_reg[IDX_W-1:0] == IDX_W'(k));

        lcs_cell #(
            .SYMBOL_BITS (SYMBOL_BITS),
            .SCORE_W     (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .wr_sym   (sym_in),
            .in_vld   (chain_vld[k]),
            .in_sym   (chain_sym[k]),
            .in_diag  (chain_diag[k]),
            .in_left  (chain_left[k]),
            .out_vld  (chain_vld[k+1]),
            .out_sym  (chain_sym[k+1]),
            .out_diag (chain_diag[k+1]),
            .out_left (chain_left[k+1])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_len_reg};
    assign m_tuser  = m_drop_reg;

    // Checks on the drain logic and finish handling
    `LCS_ASSERT_NOW(a_finish_after_drain, aclk, aresetn,
        accept && (cmd == CMD_FINISH), drain_zero && (chain_vld[MAX_LEN-1:0] == '0),
        "finish taken while a wave is still in the chain")
    `LCS_ASSERT_NEXT(a_wave_starts_drain, aclk, aresetn,
        accept && (cmd == CMD_APPEND_SECOND) && !second_full,
        wave_vld_reg && (drain_reg == DRAIN_W'(MAX_LEN + 1)),
        "second-string symbol did not start a wave")
    `LCS_ASSERT_NEXT(a_finish_clears, aclk, aresetn,
        accept && (cmd == CMD_FINISH),
        m_valid_reg && (first_len_reg == '0) && (second_len_reg == '0) && !drop_reg,
        "finish did not emit a result and clear the state")
    `LCS_ASSERT_NOW(a_first_locked, aclk, aresetn,
        second_len_reg != '0, !first_wr,
        "first string written after the second string started")

endmodule

`default_nettype wire
